// ===== src/lsf_pkg.sv =====
// Shared types and constants for the line-fit block.
`timescale 1ns / 1ps
package lsf_pkg;

  // Job field widths sized for the largest supported capacity (4096 points).
  localparam int CNTMAXW = 13;
  localparam int SUMMAXW = 37;
  localparam int SQMAXW  = 61;

  // Width of the wide arithmetic datapath in the back end.
  localparam int BIGW = 192;

  localparam int QDEPTH = 2;
  localparam int QPTRW  = 1;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_FEW    = 3'd1;
  localparam logic [2:0] ST_CONSTX = 3'd2;
  localparam logic [2:0] ST_CONSTY = 3'd3;
  localparam logic [2:0] ST_OVF    = 3'd4;

  typedef enum logic [1:0] {
    OP_MUL  = 2'd0,
    OP_DIV  = 2'd1,
    OP_SQRT = 2'd2
  } op_e_t;

  typedef struct packed {
    logic  start;
    op_e_t op;
  } alu_req_t;

  typedef struct packed {
    logic [CNTMAXW-1:0]        n;
    logic signed [SUMMAXW-1:0] sx;
    logic signed [SUMMAXW-1:0] sy;
    logic signed [SQMAXW-1:0]  sxx;
    logic signed [SQMAXW-1:0]  syy;
    logic signed [SQMAXW-1:0]  sxy;
    logic                      ovf;
  } job_t;

endpackage

// ===== src/lsf_front.sv =====
// Point accumulator: sums x, y, x^2, y^2, xy and hands a job off on the last point.
`timescale 1ns / 1ps
module lsf_front #(
  parameter int MAX_SAMPLES = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  logic signed [23:0]  x_value,
  input  logic signed [23:0]  y_value,
  input  logic                point_last,
  input  logic                q_full,
  output logic                q_push,
  output lsf_pkg::job_t       q_job
);
  import lsf_pkg::*;

  localparam int CNTW = $clog2(MAX_SAMPLES + 1);
  localparam int SW   = 24 + CNTW;
  localparam int QW   = 48 + CNTW;

  logic [CNTW-1:0]      cnt_r, cnt_nxt;
  logic signed [SW-1:0] sx_r, sx_nxt, sy_r, sy_nxt;
  logic signed [QW-1:0] sxx_r, sxx_nxt, syy_r, syy_nxt, sxy_r, sxy_nxt;
  logic                 ovf_r, ovf_nxt;
  logic signed [47:0]   pxx, pyy, pxy;
  logic                 accept, take;

  assign accept = push && !q_full;
  assign take   = cnt_r < CNTW'(MAX_SAMPLES);
  assign pxx    = x_value * x_value;
  assign pyy    = y_value * y_value;
  assign pxy    = x_value * y_value;

  always_comb begin
    cnt_nxt = cnt_r;
    sx_nxt  = sx_r;
    sy_nxt  = sy_r;
    sxx_nxt = sxx_r;
    syy_nxt = syy_r;
    sxy_nxt = sxy_r;
    ovf_nxt = ovf_r;
    if (take) begin
      cnt_nxt = cnt_r + 1'b1;
      sx_nxt  = sx_r + SW'(x_value);
      sy_nxt  = sy_r + SW'(y_value);
      sxx_nxt = sxx_r + QW'(pxx);
      syy_nxt = syy_r + QW'(pyy);
      sxy_nxt = sxy_r + QW'(pxy);
    end else begin
      ovf_nxt = 1'b1;
    end
  end

  assign q_push    = accept && point_last;
  assign q_job.n   = CNTMAXW'(cnt_nxt);
  assign q_job.sx  = SUMMAXW'(sx_nxt);
  assign q_job.sy  = SUMMAXW'(sy_nxt);
  assign q_job.sxx = SQMAXW'(sxx_nxt);
  assign q_job.syy = SQMAXW'(syy_nxt);
  assign q_job.sxy = SQMAXW'(sxy_nxt);
  assign q_job.ovf = ovf_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && point_last)) begin
      cnt_r <= '0;
      sx_r  <= '0;
      sy_r  <= '0;
      sxx_r <= '0;
      syy_r <= '0;
      sxy_r <= '0;
      ovf_r <= 1'b0;
    end else if (accept) begin
      cnt_r <= cnt_nxt;
      sx_r  <= sx_nxt;
      sy_r  <= sy_nxt;
      sxx_r <= sxx_nxt;
      syy_r <= syy_nxt;
      sxy_r <= sxy_nxt;
      ovf_r <= ovf_nxt;
    end
  end

endmodule

// ===== src/lsf_queue.sv =====
// Two-entry job queue between the accumulator and the solver.
`timescale 1ns / 1ps
module lsf_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  lsf_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output lsf_pkg::job_t pop_job,
  output logic          empty
);
  import lsf_pkg::*;

  job_t             mem_r [QDEPTH];
  logic [QPTRW-1:0] wr_r, rd_r;
  logic [QPTRW:0]   cnt_r;
  logic             do_push, do_pop;

  assign full    = cnt_r == (QPTRW+1)'(QDEPTH);
  assign empty   = cnt_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_job = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_r] <= push_job;
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wr_r <= wr_r + 1'b1;
      if (do_pop)  rd_r <= rd_r + 1'b1;
      if (do_push && !do_pop) cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

// ===== src/lsf_alu.sv =====
// Serial wide unit: shift-add multiply, restoring divide, digit-by-digit square root.
`timescale 1ns / 1ps
module lsf_alu (
  input  logic                     clk,
  input  logic                     rst_n,
  input  lsf_pkg::alu_req_t        req,
  input  logic [lsf_pkg::BIGW-1:0] a,
  input  logic [lsf_pkg::BIGW-1:0] b,
  output logic                     done,
  output logic [lsf_pkg::BIGW-1:0] res
);
  import lsf_pkg::*;

  localparam int CW = $clog2(BIGW + 1);

  logic            busy_r, done_r;
  op_e_t           op_r;
  logic [BIGW-1:0] acc_r, opa_r, opb_r, rem_r, res_r;
  logic [CW-1:0]   cnt_r;
  logic [BIGW:0]   rem_sh;
  logic            ge;
  logic [63:0]     sq_t;

  assign rem_sh = {rem_r, opa_r[BIGW-1]};
  assign ge     = rem_sh >= {1'b0, opb_r};
  assign sq_t   = acc_r[63:0] + opb_r[63:0];
  assign done   = done_r;
  assign res    = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        op_r   <= req.op;
        unique case (req.op)
          OP_MUL: begin
            acc_r <= '0;
            opa_r <= a;
            opb_r <= b;
          end
          OP_DIV: begin
            opa_r <= a;
            opb_r <= b;
            rem_r <= '0;
            cnt_r <= CW'(BIGW);
          end
          OP_SQRT: begin
            opa_r <= a;
            acc_r <= '0;
            opb_r <= BIGW'(64'h4000_0000_0000_0000);
            cnt_r <= CW'(32);
          end
          default: busy_r <= 1'b0;
        endcase
      end else if (busy_r) begin
        unique case (op_r)
          OP_MUL: begin
            if (opb_r == '0) begin
              busy_r <= 1'b0;
              done_r <= 1'b1;
              res_r  <= acc_r;
            end else begin
              if (opb_r[0]) acc_r <= acc_r + opa_r;
              opa_r <= opa_r << 1;
              opb_r <= opb_r >> 1;
            end
          end
          OP_DIV: begin
            if (cnt_r == '0) begin
              busy_r <= 1'b0;
              done_r <= 1'b1;
              res_r  <= (opb_r == '0) ? '0 : opa_r;
            end else begin
              rem_r <= ge ? BIGW'(rem_sh - {1'b0, opb_r}) : BIGW'(rem_sh);
              opa_r <= {opa_r[BIGW-2:0], ge};
              cnt_r <= cnt_r - 1'b1;
            end
          end
          OP_SQRT: begin
            if (cnt_r == '0) begin
              busy_r <= 1'b0;
              done_r <= 1'b1;
              res_r  <= BIGW'(acc_r[31:0]);
            end else begin
              if (opa_r[63:0] >= sq_t) begin
                opa_r <= BIGW'(opa_r[63:0] - sq_t);
                acc_r <= BIGW'((acc_r[63:0] >> 1) + opb_r[63:0]);
              end else begin
                acc_r <= BIGW'(acc_r[63:0] >> 1);
              end
              opb_r <= BIGW'(opb_r[63:0] >> 2);
              cnt_r <= cnt_r - 1'b1;
            end
          end
          default: busy_r <= 1'b0;
        endcase
      end
    end
  end

endmodule

// ===== src/lsf_back.sv =====
// Solver sequencer: centered sums, slope, r^2 and slope standard error for one job.
`timescale 1ns / 1ps
module lsf_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  lsf_pkg::job_t        q_job,
  output logic                 q_pop,
  output logic                 res_valid,
  input  logic                 res_take,
  output logic signed [31:0]   fit_slope,
  output logic [31:0]          slope_std_error,
  output logic [16:0]          r_squared,
  output logic [10:0]          points_used,
  output logic [2:0]           fit_status
);
  import lsf_pkg::*;

  typedef enum logic [16:0] {
    S_IDLE  = 17'b00000000000000001,
    S_NXX   = 17'b00000000000000010,
    S_XX    = 17'b00000000000000100,
    S_NYY   = 17'b00000000000001000,
    S_YY    = 17'b00000000000010000,
    S_NXY   = 17'b00000000000100000,
    S_XY    = 17'b00000000001000000,
    S_CHECK = 17'b00000000010000000,
    S_SLOPE = 17'b00000000100000000,
    S_U     = 17'b00000001000000000,
    S_S2    = 17'b00000010000000000,
    S_R2    = 17'b00000100000000000,
    S_DEN1  = 17'b00001000000000000,
    S_DEN2  = 17'b00010000000000000,
    S_SEDIV = 17'b00100000000000000,
    S_SQRT  = 17'b01000000000000000,
    S_DONE  = 17'b10000000000000000
  } state_t;

  function automatic logic [BIGW-1:0] neg_big(input logic [BIGW-1:0] v);
    neg_big = ~v + 1'b1;
  endfunction

  function automatic logic [BIGW-1:0] abs_big(input logic [BIGW-1:0] v);
    abs_big = v[BIGW-1] ? neg_big(v) : v;
  endfunction

  state_t          state_r, state_nxt;
  job_t            job_r;
  logic            go_r, go_nxt;
  logic [BIGW-1:0] t1_r, t1_nxt, sxx_r, sxx_nxt, syy_r, syy_nxt, sxy_r, sxy_nxt;
  logic [BIGW-1:0] u_r, u_nxt, s2_r, s2_nxt;
  logic            nxy_r, nxy_nxt;
  logic [31:0]     slope_r, slope_nxt, se_r, se_nxt;
  logic [16:0]     r2_r, r2_nxt;
  logic [2:0]      status_r, status_nxt, fin_status;
  alu_req_t        req;
  logic [BIGW-1:0] opa, opb, alu_res, prod, diff, nbig;
  logic            neg_sel, alu_done;
  logic [BIGW-1:0] ex_sx, ex_sy, ex_sxx, ex_syy, ex_sxy;

  assign ex_sx  = BIGW'(job_r.sx);
  assign ex_sy  = BIGW'(job_r.sy);
  assign ex_sxx = BIGW'(job_r.sxx);
  assign ex_syy = BIGW'(job_r.syy);
  assign ex_sxy = BIGW'(job_r.sxy);
  assign nbig   = BIGW'(job_r.n);

  lsf_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .a     (opa),
    .b     (opb),
    .done  (alu_done),
    .res   (alu_res)
  );

  always_comb begin
    opa       = '0;
    opb       = '0;
    neg_sel   = 1'b0;
    req.start = go_r;
    req.op    = OP_MUL;
    unique case (state_r)
      S_NXX: begin
        opa = abs_big(ex_sxx); opb = nbig; neg_sel = job_r.sxx[SQMAXW-1];
      end
      S_XX: begin
        opa = abs_big(ex_sx); opb = abs_big(ex_sx);
      end
      S_NYY: begin
        opa = abs_big(ex_syy); opb = nbig; neg_sel = job_r.syy[SQMAXW-1];
      end
      S_YY: begin
        opa = abs_big(ex_sy); opb = abs_big(ex_sy);
      end
      S_NXY: begin
        opa = abs_big(ex_sxy); opb = nbig; neg_sel = job_r.sxy[SQMAXW-1];
      end
      S_XY: begin
        opa = abs_big(ex_sx); opb = abs_big(ex_sy);
        neg_sel = job_r.sx[SUMMAXW-1] ^ job_r.sy[SUMMAXW-1];
      end
      S_SLOPE: begin
        opa = sxy_r << 16; opb = sxx_r; req.op = OP_DIV;
      end
      S_U: begin
        opa = sxx_r; opb = syy_r;
      end
      S_S2: begin
        opa = sxy_r; opb = sxy_r;
      end
      S_R2: begin
        opa = s2_r << 16; opb = u_r; req.op = OP_DIV;
      end
      S_DEN1: begin
        opa = sxx_r; opb = sxx_r;
      end
      S_DEN2: begin
        opa = t1_r; opb = nbig - BIGW'(2);
      end
      S_SEDIV: begin
        opa = (u_r - s2_r) << 32; opb = t1_r; req.op = OP_DIV;
      end
      S_SQRT: begin
        opa = t1_r; req.op = OP_SQRT;
      end
      S_IDLE, S_CHECK, S_DONE: begin
        opa = '0;
      end
      default: opa = '0;
    endcase
  end

  assign prod      = neg_sel ? neg_big(alu_res) : alu_res;
  assign diff      = t1_r - prod;
  assign fin_status = (syy_r == '0) ? ST_CONSTY : (job_r.ovf ? ST_OVF : ST_OK);

  always_comb begin
    state_nxt  = state_r;
    go_nxt     = 1'b0;
    t1_nxt     = t1_r;
    sxx_nxt    = sxx_r;
    syy_nxt    = syy_r;
    sxy_nxt    = sxy_r;
    nxy_nxt    = nxy_r;
    u_nxt      = u_r;
    s2_nxt     = s2_r;
    slope_nxt  = slope_r;
    se_nxt     = se_r;
    r2_nxt     = r2_r;
    status_nxt = status_r;
    q_pop      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          state_nxt = S_NXX;
          go_nxt    = 1'b1;
        end
      end
      S_NXX, S_NYY, S_NXY: begin
        if (alu_done) begin
          t1_nxt    = prod;
          state_nxt = (state_r == S_NXX) ? S_XX : ((state_r == S_NYY) ? S_YY : S_XY);
          go_nxt    = 1'b1;
        end
      end
      S_XX: begin
        if (alu_done) begin
          sxx_nxt   = diff[BIGW-1] ? '0 : diff;
          state_nxt = S_NYY;
          go_nxt    = 1'b1;
        end
      end
      S_YY: begin
        if (alu_done) begin
          syy_nxt   = diff[BIGW-1] ? '0 : diff;
          state_nxt = S_NXY;
          go_nxt    = 1'b1;
        end
      end
      S_XY: begin
        if (alu_done) begin
          nxy_nxt   = diff[BIGW-1];
          sxy_nxt   = abs_big(diff);
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        slope_nxt = '0;
        se_nxt    = '0;
        r2_nxt    = '0;
        if (job_r.n < CNTMAXW'(3)) begin
          status_nxt = ST_FEW;
          state_nxt  = S_DONE;
        end else if (sxx_r == '0) begin
          status_nxt = ST_CONSTX;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_SLOPE;
          go_nxt    = 1'b1;
        end
      end
      S_SLOPE: begin
        if (alu_done) begin
          if ((alu_res[BIGW-1:32] != '0) ||
              (nxy_r ? (alu_res[31:0] > 32'h8000_0000) : (alu_res[31:0] > 32'h7FFF_FFFF)))
            slope_nxt = nxy_r ? 32'h8000_0000 : 32'h7FFF_FFFF;
          else
            slope_nxt = nxy_r ? (~alu_res[31:0] + 1'b1) : alu_res[31:0];
          state_nxt = S_U;
          go_nxt    = 1'b1;
        end
      end
      S_U: begin
        if (alu_done) begin
          u_nxt = alu_res;
          if (alu_res == '0) begin
            status_nxt = fin_status;
            state_nxt  = S_DONE;
          end else begin
            state_nxt = S_S2;
            go_nxt    = 1'b1;
          end
        end
      end
      S_S2: begin
        if (alu_done) begin
          s2_nxt    = alu_res;
          state_nxt = S_R2;
          go_nxt    = 1'b1;
        end
      end
      S_R2: begin
        if (alu_done) begin
          r2_nxt = (alu_res > BIGW'(65536)) ? 17'h10000 : alu_res[16:0];
          if (u_r > s2_r) begin
            state_nxt = S_DEN1;
            go_nxt    = 1'b1;
          end else begin
            status_nxt = fin_status;
            state_nxt  = S_DONE;
          end
        end
      end
      S_DEN1, S_DEN2: begin
        if (alu_done) begin
          t1_nxt    = alu_res;
          state_nxt = (state_r == S_DEN1) ? S_DEN2 : S_SEDIV;
          go_nxt    = 1'b1;
        end
      end
      S_SEDIV: begin
        if (alu_done) begin
          t1_nxt = alu_res;
          if (alu_res[BIGW-1:64] != '0) begin
            se_nxt     = 32'hFFFF_FFFF;
            status_nxt = fin_status;
            state_nxt  = S_DONE;
          end else begin
            state_nxt = S_SQRT;
            go_nxt    = 1'b1;
          end
        end
      end
      S_SQRT: begin
        if (alu_done) begin
          se_nxt     = alu_res[31:0];
          status_nxt = fin_status;
          state_nxt  = S_DONE;
        end
      end
      S_DONE: begin
        if (res_take) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      go_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      go_r    <= go_nxt;
    end
    if (q_pop) job_r <= q_job;
    t1_r     <= t1_nxt;
    sxx_r    <= sxx_nxt;
    syy_r    <= syy_nxt;
    sxy_r    <= sxy_nxt;
    nxy_r    <= nxy_nxt;
    u_r      <= u_nxt;
    s2_r     <= s2_nxt;
    slope_r  <= slope_nxt;
    se_r     <= se_nxt;
    r2_r     <= r2_nxt;
    status_r <= status_nxt;
  end

  assign res_valid       = state_r == S_DONE;
  assign fit_slope       = slope_r;
  assign slope_std_error = se_r;
  assign r_squared       = r2_r;
  assign points_used     = job_r.n[10:0];
  assign fit_status      = status_r;

endmodule

// ===== src/least_squares_line_fit_top.sv =====
// Top level of the streaming least-squares line fit.
`timescale 1ns / 1ps
// Takes one (x, y) point per clock; every point, last or not, stalls while the
// two-entry job queue is full, which happens only when two finished data sets
// wait behind the solver. Each data set's result comes out of a serial solver
// that runs a shift-add multiplier, a restoring divide (up to three per set)
// and a digit-by-digit square root. Points past MAX_SAMPLES are dropped and
// flagged in the status, unless a constant-x or constant-y status takes its
// place. No reset sweep is needed.
module least_squares_line_fit_top #(
  parameter int MAX_SAMPLES = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic signed [23:0] in_x_value,
  input  logic signed [23:0] in_y_value,
  input  logic               in_point_last,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [31:0] out_fit_slope,
  output logic [31:0]        out_slope_std_error,
  output logic [16:0]        out_r_squared,
  output logic [10:0]        out_points_used,
  output logic [2:0]         out_fit_status
);
  import lsf_pkg::*;

  logic q_push, q_full, q_pop, q_empty, res_valid;
  job_t push_job, pop_job;

  lsf_front #(.MAX_SAMPLES(MAX_SAMPLES)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_push),
    .x_value    (in_x_value),
    .y_value    (in_y_value),
    .point_last (in_point_last),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_job      (push_job)
  );

  lsf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .empty    (q_empty)
  );

  lsf_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_job           (pop_job),
    .q_pop           (q_pop),
    .res_valid       (res_valid),
    .res_take        (out_pop),
    .fit_slope       (out_fit_slope),
    .slope_std_error (out_slope_std_error),
    .r_squared       (out_r_squared),
    .points_used     (out_points_used),
    .fit_status      (out_fit_status)
  );

  assign in_full   = q_full;
  assign out_empty = !res_valid;

endmodule
